>>> rtl/adaptation_loop_level_control_assert.svh
// ----------------------------------------------------------------------------
// adaptation_loop_level_control_assert.svh
// Assertion macros for the level control checker.
// ----------------------------------------------------------------------------
`ifndef ADAPTATION_LOOP_LEVEL_CONTROL_ASSERT_SVH
`define ADAPTATION_LOOP_LEVEL_CONTROL_ASSERT_SVH

// antecedent holds now, consequent must hold in the next cycle
`define ALC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// antecedent and consequent in the same cycle
`define ALC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> rtl/alc_pkg.sv
// ----------------------------------------------------------------------------
// alc_pkg
// Shared constants, types and the tanh table for the level control block.
// ----------------------------------------------------------------------------
package alc_pkg;

  localparam int MAX_STAGES = 5;
  localparam int STAGE_BITS = $clog2(MAX_STAGES + 1);
  localparam int TANH_TABLE_DEPTH = 256;
  localparam int TAB_BITS = $clog2(TANH_TABLE_DEPTH);
  localparam int SPAN_SHIFT = 27;
  localparam int FRAC_BITS = SPAN_SHIFT - TAB_BITS;

  localparam logic [31:0] ONE_Q24 = 32'h0100_0000;
  localparam logic [31:0] MAG_MAX = 32'h7FFF_FFFF;
  localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
  localparam logic [63:0] EXP_M1_Q30 = 64'd395007543;

  localparam logic [5:0] DIV_Q_STEPS = 6'd56;
  localparam logic [5:0] DIV_X_STEPS = 6'd27;
  localparam logic [5:0] DIV_U_STEPS = 6'd32;

  localparam logic [2:0] CFG_STAGE_COUNT = 3'd0;
  localparam logic [2:0] CFG_OVERSHOOT   = 3'd1;
  localparam logic [2:0] CFG_THRESHOLD   = 3'd2;
  localparam logic [2:0] CFG_TAU0        = 3'd3;
  localparam logic [2:0] CFG_TAU1        = 3'd4;
  localparam logic [2:0] CFG_TAU2        = 3'd5;
  localparam logic [2:0] CFG_TAU3        = 3'd6;
  localparam logic [2:0] CFG_TAU4        = 3'd7;

  localparam logic [3:0] OP_NONE   = 4'd0;
  localparam logic [3:0] OP_LOAD   = 4'd1;
  localparam logic [3:0] OP_DIV1   = 4'd2;
  localparam logic [3:0] OP_TAKE_Q = 4'd3;
  localparam logic [3:0] OP_CLIP   = 4'd4;
  localparam logic [3:0] OP_TMAX   = 4'd5;
  localparam logic [3:0] OP_DIV2   = 4'd6;
  localparam logic [3:0] OP_INT1   = 4'd7;
  localparam logic [3:0] OP_INT2   = 4'd8;
  localparam logic [3:0] OP_SCALE  = 4'd9;
  localparam logic [3:0] OP_FIN    = 4'd10;
  localparam logic [3:0] OP_MUL    = 4'd11;
  localparam logic [3:0] OP_DIV3   = 4'd12;
  localparam logic [3:0] OP_WRITE  = 4'd13;
  localparam logic [3:0] OP_OUT    = 4'd14;

  typedef struct packed {
    logic [3:0] op;
  } cmd_t;

  typedef struct packed {
    logic div_idle;
    logic q_small;
    logic l_zero;
    logic d_big;
    logic last;
    logic out_busy;
  } status_t;

  typedef logic [24:0] tanh_tab_t [0:TANH_TABLE_DEPTH];

  // shift-subtract long division, only used while building the table
  function automatic logic [63:0] udiv64(logic [63:0] a, logic [63:0] b);
    logic [64:0] r;
    logic [63:0] q;
    int i;
    r = '0;
    q = '0;
    for (i = 63; i >= 0; i--) begin
      r = {r[63:0], a[i]};
      if (r >= {1'b0, b}) begin
        r = r - {1'b0, b};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] exp_neg_q30(logic [63:0] y);
    logic [63:0] n;
    logic [63:0] f;
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] e;
    int k;
    n = y >> 24;
    f = (y & 64'hFF_FFFF) << 6;
    sum = ONE_Q30;
    term = ONE_Q30;
    for (k = 1; k <= 20; k++) begin
      term = udiv64((term * f) >> 30, 64'(k));
      sum = sum + term;
    end
    e = udiv64(64'd1 << 60, sum);
    for (k = 0; k < 16; k++) begin
      if (64'(k) < n) begin
        e = (e * EXP_M1_Q30) >> 30;
      end
    end
    return e;
  endfunction

  function automatic tanh_tab_t build_tanh_tab();
    tanh_tab_t tab;
    logic [63:0] x;
    logic [63:0] e;
    int i;
    for (i = 0; i <= TANH_TABLE_DEPTH; i++) begin
      x = (64'(i) << SPAN_SHIFT) >> TAB_BITS;
      e = exp_neg_q30(x << 1);
      tab[i] = 25'(udiv64((ONE_Q30 - e) << 24, ONE_Q30 + e));
    end
    return tab;
  endfunction

  localparam tanh_tab_t TANH_TAB = build_tanh_tab();

endpackage

>>> rtl/adaptation_loop_level_control.sv
// ----------------------------------------------------------------------------
// adaptation_loop_level_control
// Chain of up to five adaptation stages with a tanh overshoot limiter.
// ----------------------------------------------------------------------------
// Timing: each stage is slowest when the limiter interpolates and fastest when it
//   passes the sample; all selected stages run one after another for each request.
// Throughput: a new request is taken only once the previous one has finished; the
//   bit-serial divider sets the pace. The result register frees the input side while a result waits.
// Reset: synchronous; dividers go to 1.0 and configuration registers to their defaults.
module adaptation_loop_level_control (
  input  logic        clk,
  input  logic        rst,
  input  logic        sample_valid,
  output logic        sample_ready,
  input  logic [31:0] sample_in,
  input  logic        channel_start,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [31:0] adapted_sample,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [30:0] cfg_data
);

  alc_pkg::cmd_t    cmd;
  alc_pkg::status_t status;

  alc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .status       (status),
    .cmd          (cmd)
  );

  alc_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .sample_in      (sample_in),
    .channel_start  (channel_start),
    .adapted_sample (adapted_sample),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

endmodule

>>> rtl/alc_div.sv
// ----------------------------------------------------------------------------
// alc_div
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module alc_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] rem_init,
  input  logic [63:0] quo_init,
  input  logic [31:0] divisor,
  input  logic [5:0]  steps,
  output logic [63:0] quotient,
  output logic        idle
);

  logic [5:0]  cnt;
  logic [31:0] rem;
  logic [63:0] quo;
  logic [31:0] dsr;
  logic [32:0] trial;
  logic [31:0] rem_next;
  logic        qbit;

  always_comb begin
    trial = {rem, quo[63]};
    if (trial >= {1'b0, dsr}) begin
      rem_next = 32'(trial - {1'b0, dsr});
      qbit = 1'b1;
    end else begin
      rem_next = trial[31:0];
      qbit = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= steps;
    end else if (cnt != 6'd0) begin
      cnt <= cnt - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= rem_init;
      quo <= quo_init;
      dsr <= divisor;
    end else if (cnt != 6'd0) begin
      rem <= rem_next;
      quo <= {quo[62:0], qbit};
    end
  end

  assign quotient = quo;
  assign idle = (cnt == 6'd0);

endmodule

>>> rtl/alc_dp.sv
// ----------------------------------------------------------------------------
// alc_dp
// Datapath: configuration, stage dividers, limiter and lowpass update.
// ----------------------------------------------------------------------------
module alc_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  alc_pkg::cmd_t        cmd,
  output alc_pkg::status_t     status,
  input  logic [31:0]          sample_in,
  input  logic                 channel_start,
  output logic [31:0]          adapted_sample,
  output logic                 result_valid,
  input  logic                 result_ready,
  input  logic                 cfg_write,
  input  logic [2:0]           cfg_index,
  input  logic [30:0]          cfg_data
);

  logic [2:0]  stage_count;
  logic [30:0] overshoot_limit;
  logic [30:0] quiet_threshold;
  logic [15:0] tau [alc_pkg::MAX_STAGES];
  logic [31:0] divider [alc_pkg::MAX_STAGES];

  logic                         neg;
  logic [31:0]                  mag;
  logic [alc_pkg::STAGE_BITS-1:0] stage;
  logic [alc_pkg::STAGE_BITS-1:0] last_stage;
  logic [24:0]                  t;
  logic [24:0]                  lo;
  logic [24:0]                  ipart;
  logic [55:0]                  sprod;
  logic [47:0]                  uprod;

  logic        div_start;
  logic [31:0] div_rem_init;
  logic [63:0] div_quo_init;
  logic [31:0] div_divisor;
  logic [5:0]  div_steps;
  logic [63:0] div_quo;
  logic        div_idle;

  logic [31:0] dv_raw;
  logic [31:0] dv_eff;
  logic [15:0] tau_eff;
  logic [31:0] thr;
  logic [31:0] m;
  logic [55:0] q;
  logic [55:0] d;
  logic [48:0] num;
  logic [alc_pkg::TAB_BITS-1:0]  tix;
  logic [alc_pkg::FRAC_BITS-1:0] frac;
  logic [24:0] hi_v;
  logic [24:0] lo_v;
  logic [24:0] delta;
  logic [32:0] scaled;
  logic [2:0]  n_clamped;

  alc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .rem_init (div_rem_init),
    .quo_init (div_quo_init),
    .divisor  (div_divisor),
    .steps    (div_steps),
    .quotient (div_quo),
    .idle     (div_idle)
  );

  always_comb begin
    dv_raw = divider[stage];
    dv_eff = (dv_raw == 32'd0) ? 32'd1 : dv_raw;
    tau_eff = (tau[stage] == 16'd0) ? 16'd1 : tau[stage];
    thr = (quiet_threshold == 31'd0) ? 32'd1 : {1'b0, quiet_threshold};
    m = (mag > thr) ? mag : thr;
    q = div_quo[55:0];
    d = q - 56'(alc_pkg::ONE_Q24);
    num = 49'(m) + 49'(uprod);
    tix = div_quo[alc_pkg::SPAN_SHIFT-1:alc_pkg::FRAC_BITS];
    frac = div_quo[alc_pkg::FRAC_BITS-1:0];
    lo_v = alc_pkg::TANH_TAB[{1'b0, tix}];
    hi_v = alc_pkg::TANH_TAB[(alc_pkg::TAB_BITS+1)'(tix) + 1'b1];
    delta = (hi_v >= lo_v) ? hi_v - lo_v : 25'd0;
    scaled = 33'(sprod[55:24]) + 33'(alc_pkg::ONE_Q24);
    if (stage_count == 3'd0) begin
      n_clamped = 3'd1;
    end else if (stage_count > 3'(alc_pkg::MAX_STAGES)) begin
      n_clamped = 3'(alc_pkg::MAX_STAGES);
    end else begin
      n_clamped = stage_count;
    end
  end

  always_comb begin
    div_start = 1'b0;
    div_rem_init = '0;
    div_quo_init = {mag, 32'd0};
    div_divisor = dv_eff;
    div_steps = alc_pkg::DIV_Q_STEPS;
    case (cmd.op)
      alc_pkg::OP_DIV1: begin
        div_start = 1'b1;
      end
      alc_pkg::OP_DIV2: begin
        div_start = 1'b1;
        div_rem_init = 32'(d[33:3]);
        div_quo_init = {d[2:0], 61'd0};
        div_divisor = {1'b0, overshoot_limit};
        div_steps = alc_pkg::DIV_X_STEPS;
      end
      alc_pkg::OP_DIV3: begin
        div_start = 1'b1;
        div_rem_init = 32'(num[48:32]);
        div_quo_init = {num[31:0], 32'd0};
        div_divisor = {16'd0, tau_eff};
        div_steps = alc_pkg::DIV_U_STEPS;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_count <= 3'd5;
      overshoot_limit <= 31'd150994944;
      quiet_threshold <= 31'd168;
      tau[0] <= 16'd80;
      tau[1] <= 16'd800;
      tau[2] <= 16'd2064;
      tau[3] <= 16'd4048;
      tau[4] <= 16'd8000;
    end else if (cfg_write) begin
      case (cfg_index)
        alc_pkg::CFG_STAGE_COUNT: stage_count <= cfg_data[2:0];
        alc_pkg::CFG_OVERSHOOT:   overshoot_limit <= cfg_data;
        alc_pkg::CFG_THRESHOLD:   quiet_threshold <= cfg_data;
        alc_pkg::CFG_TAU0:        tau[0] <= cfg_data[15:0];
        alc_pkg::CFG_TAU1:        tau[1] <= cfg_data[15:0];
        alc_pkg::CFG_TAU2:        tau[2] <= cfg_data[15:0];
        alc_pkg::CFG_TAU3:        tau[3] <= cfg_data[15:0];
        alc_pkg::CFG_TAU4:        tau[4] <= cfg_data[15:0];
        default: stage_count <= stage_count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < alc_pkg::MAX_STAGES; k++) begin
        divider[k] <= alc_pkg::ONE_Q24;
      end
      stage <= '0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      case (cmd.op)
        alc_pkg::OP_LOAD: begin
          stage <= '0;
          if (channel_start) begin
            for (int k = 0; k < alc_pkg::MAX_STAGES; k++) begin
              divider[k] <= alc_pkg::ONE_Q24;
            end
          end
        end
        alc_pkg::OP_WRITE: begin
          divider[stage] <= div_quo[31:0];
          stage <= stage + 1'b1;
        end
        alc_pkg::OP_OUT: begin
          result_valid <= 1'b1;
        end
        default: begin
          stage <= stage;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      alc_pkg::OP_LOAD: begin
        neg <= sample_in[31];
        mag <= sample_in[31] ? 32'(33'h1_0000_0000 - 33'(sample_in)) : sample_in;
        last_stage <= alc_pkg::STAGE_BITS'(n_clamped - 3'd1);
      end
      alc_pkg::OP_TAKE_Q: mag <= q[31:0];
      alc_pkg::OP_CLIP:   mag <= alc_pkg::ONE_Q24;
      alc_pkg::OP_TMAX:   t <= alc_pkg::TANH_TAB[alc_pkg::TANH_TABLE_DEPTH];
      alc_pkg::OP_INT1: begin
        lo <= lo_v;
        ipart <= 25'((44'(delta) * 44'(frac)) >> alc_pkg::FRAC_BITS);
      end
      alc_pkg::OP_INT2:  t <= lo + ipart;
      alc_pkg::OP_SCALE: sprod <= 56'(overshoot_limit) * 56'(t);
      alc_pkg::OP_FIN:   mag <= (scaled > 33'(alc_pkg::MAG_MAX)) ? alc_pkg::MAG_MAX
                                                                 : scaled[31:0];
      alc_pkg::OP_MUL:   uprod <= 48'(dv_raw) * 48'(tau_eff - 16'd1);
      alc_pkg::OP_OUT:   adapted_sample <= neg ? 32'(-mag) : mag;
      default: mag <= mag;
    endcase
  end

  always_comb begin
    status.div_idle = div_idle;
    status.q_small = (q <= 56'(alc_pkg::ONE_Q24));
    status.l_zero = (overshoot_limit == 31'd0);
    status.d_big = (d >= 56'({overshoot_limit, 3'b000}));
    status.last = (stage == last_stage);
    status.out_busy = result_valid && !result_ready;
  end

endmodule

>>> rtl/alc_ctrl.sv
// ----------------------------------------------------------------------------
// alc_ctrl
// Sequencer: walks each request through the stages and issues datapath ops.
// ----------------------------------------------------------------------------
module alc_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             sample_valid,
  output logic             sample_ready,
  input  alc_pkg::status_t status,
  output alc_pkg::cmd_t    cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DIV1  = 4'd1;
  localparam logic [3:0] S_W1    = 4'd2;
  localparam logic [3:0] S_LIM   = 4'd3;
  localparam logic [3:0] S_W2    = 4'd4;
  localparam logic [3:0] S_INT1  = 4'd5;
  localparam logic [3:0] S_INT2  = 4'd6;
  localparam logic [3:0] S_SCALE = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;
  localparam logic [3:0] S_MUL   = 4'd9;
  localparam logic [3:0] S_D3    = 4'd10;
  localparam logic [3:0] S_W3    = 4'd11;
  localparam logic [3:0] S_WRITE = 4'd12;
  localparam logic [3:0] S_OUT   = 4'd13;

  logic [3:0] state;
  logic [3:0] state_next;

  always_comb begin
    state_next = state;
    cmd.op = alc_pkg::OP_NONE;
    sample_ready = (state == S_IDLE);
    case (state)
      S_IDLE: begin
        if (sample_valid) begin
          cmd.op = alc_pkg::OP_LOAD;
          state_next = S_DIV1;
        end
      end
      S_DIV1: begin
        cmd.op = alc_pkg::OP_DIV1;
        state_next = S_W1;
      end
      S_W1: begin
        if (status.div_idle) state_next = S_LIM;
      end
      S_LIM: begin
        if (status.q_small) begin
          cmd.op = alc_pkg::OP_TAKE_Q;
          state_next = S_MUL;
        end else if (status.l_zero) begin
          cmd.op = alc_pkg::OP_CLIP;
          state_next = S_MUL;
        end else if (status.d_big) begin
          cmd.op = alc_pkg::OP_TMAX;
          state_next = S_SCALE;
        end else begin
          cmd.op = alc_pkg::OP_DIV2;
          state_next = S_W2;
        end
      end
      S_W2: begin
        if (status.div_idle) state_next = S_INT1;
      end
      S_INT1: begin
        cmd.op = alc_pkg::OP_INT1;
        state_next = S_INT2;
      end
      S_INT2: begin
        cmd.op = alc_pkg::OP_INT2;
        state_next = S_SCALE;
      end
      S_SCALE: begin
        cmd.op = alc_pkg::OP_SCALE;
        state_next = S_FIN;
      end
      S_FIN: begin
        cmd.op = alc_pkg::OP_FIN;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.op = alc_pkg::OP_MUL;
        state_next = S_D3;
      end
      S_D3: begin
        cmd.op = alc_pkg::OP_DIV3;
        state_next = S_W3;
      end
      S_W3: begin
        if (status.div_idle) state_next = S_WRITE;
      end
      S_WRITE: begin
        cmd.op = alc_pkg::OP_WRITE;
        state_next = status.last ? S_OUT : S_DIV1;
      end
      S_OUT: begin
        if (!status.out_busy) begin
          cmd.op = alc_pkg::OP_OUT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> rtl/alc_checker.sv
// ----------------------------------------------------------------------------
// alc_checker
// Port-level checks on the level control block, bound to the top level.
// ----------------------------------------------------------------------------
`include "adaptation_loop_level_control_assert.svh"

module alc_checker (
  input logic        clk,
  input logic        rst,
  input logic        sample_valid,
  input logic        sample_ready,
  input logic        result_valid,
  input logic        result_ready,
  input logic [31:0] adapted_sample
);

  `ALC_ASSERT_NEXT(a_out_hold, result_valid && !result_ready, result_valid && $stable(adapted_sample), "stalled result changed")
  `ALC_ASSERT_NEXT(a_busy_after_accept, sample_valid && sample_ready, !sample_ready, "request taken while busy")
  `ALC_ASSERT_NEXT(a_no_instant_result, sample_valid && sample_ready, !$rose(result_valid), "result too early")
  `ALC_ASSERT_NOW(a_sym_range, result_valid, adapted_sample != 32'h8000_0000, "result outside symmetric range")
  `ALC_ASSERT_NOW(a_reset_clear, $past(rst), !result_valid, "result valid out of reset")

endmodule

bind adaptation_loop_level_control alc_checker u_alc_checker (
  .clk            (clk),
  .rst            (rst),
  .sample_valid   (sample_valid),
  .sample_ready   (sample_ready),
  .result_valid   (result_valid),
  .result_ready   (result_ready),
  .adapted_sample (adapted_sample)
);
